@@ design/tlb_pt_pkg.sv @@
// Shared constants, controller state codes and command/status types of the TLB page translator.
package tlb_pt_pkg;

    localparam int TLB_ENTRIES_DEFAULT       = 16;
    localparam int FRAME_COUNT_DEFAULT       = 64;
    localparam int OFFSET_WIDTH_DEFAULT      = 8;
    localparam int PAGE_NUMBER_WIDTH_DEFAULT = 8;
    localparam int STAMP_WIDTH               = 32;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOOK   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_COMMIT = 4'b1000
    } t_state;

    typedef struct packed {
        logic accept;
        logic look;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic out_free;
    } t_status;

endpackage

@@ design/tlb_pt_ctrl.sv @@
// Controller state machine of the TLB page translator.
module tlb_pt_ctrl
    import tlb_pt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_ready      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // Nothing is taken while reset is held.
                o_ready      = i_rst_n;
                o_cmd.accept = i_valid && i_rst_n;
                if (o_cmd.accept) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = i_status.need_scan ? ST_SCAN : ST_COMMIT;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/tlb_pt_dpath.sv @@
// Datapath of the TLB page translator: TLB, frame table, stamp memory and output register.
module tlb_pt_dpath
    import tlb_pt_pkg::*;
#(
    parameter int TLB_ENTRIES       = TLB_ENTRIES_DEFAULT,
    parameter int FRAME_COUNT       = FRAME_COUNT_DEFAULT,
    parameter int OFFSET_WIDTH      = OFFSET_WIDTH_DEFAULT,
    parameter int PAGE_NUMBER_WIDTH = PAGE_NUMBER_WIDTH_DEFAULT,
    localparam int TW = $clog2(TLB_ENTRIES),
    localparam int FW = $clog2(FRAME_COUNT),
    localparam int VW = OFFSET_WIDTH + PAGE_NUMBER_WIDTH,
    localparam int PW = FW + OFFSET_WIDTH
)
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_wr_data,
    input  logic [VW-1:0] i_virtual_address,
    input  t_cmd          i_cmd,
    output t_status       o_status,
    input  logic          i_ready,
    output logic          o_valid,
    output logic [PW-1:0] o_phys_addr,
    output logic          o_tlb_hit,
    output logic          o_page_fault
);

    logic                         r_mode;
    logic [PAGE_NUMBER_WIDTH-1:0] r_page;
    logic [OFFSET_WIDTH-1:0]      r_offset;
    logic [STAMP_WIDTH-1:0]       r_clock;

    logic [PAGE_NUMBER_WIDTH-1:0] r_tlb_tag   [TLB_ENTRIES];
    logic [FW-1:0]                r_tlb_frame [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0]       r_tlb_valid;
    logic [TW-1:0]                r_tlb_ptr;

    logic [PAGE_NUMBER_WIDTH-1:0] r_owner [FRAME_COUNT];
    logic [FRAME_COUNT-1:0]       r_occ;
    logic [FW-1:0]                r_victim_ptr;

    logic [STAMP_WIDTH-1:0]       r_stamp_mem [FRAME_COUNT];
    logic [STAMP_WIDTH-1:0]       r_stamp_rd;

    logic                         r_hit;
    logic                         r_fault;
    logic [FW-1:0]                r_frame;

    logic [FW-1:0]                r_scan_addr;
    logic                         r_scan_issue;
    logic                         r_cmp_valid;
    logic [FW-1:0]                r_cmp_idx;
    logic [STAMP_WIDTH-1:0]       r_best;

    logic                         r_out_valid;
    logic [PW-1:0]                r_out_pa;
    logic                         r_out_hit;
    logic                         r_out_fault;

    logic          tlb_hit;
    logic [TW-1:0] tlb_idx;
    logic          frm_hit;
    logic [FW-1:0] frm_idx;
    logic [FW-1:0] empty_idx;
    logic          all_full;
    logic          out_free;

    localparam logic [TW-1:0] TLB_LAST   = TW'(TLB_ENTRIES - 1);
    localparam logic [FW-1:0] FRAME_LAST = FW'(FRAME_COUNT - 1);

    // Parallel tag compares; the lowest matching index wins.
    always_comb begin
        tlb_hit   = 1'b0;
        tlb_idx   = '0;
        frm_hit   = 1'b0;
        frm_idx   = '0;
        empty_idx = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (r_tlb_valid[i] && r_tlb_tag[i] == r_page) begin
                tlb_hit = 1'b1;
                tlb_idx = TW'(i);
            end
        end
        for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
            if (r_occ[i] && r_owner[i] == r_page) begin
                frm_hit = 1'b1;
                frm_idx = FW'(i);
            end
            if (!r_occ[i]) begin
                empty_idx = FW'(i);
            end
        end
    end

    assign all_full = &r_occ;
    assign out_free = !r_out_valid || i_ready;

    assign o_status.need_scan = !tlb_hit && !frm_hit && all_full && r_mode;
    assign o_status.scan_done = r_cmp_valid && (r_cmp_idx == FRAME_LAST);
    assign o_status.out_free  = out_free;

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 1'b0;
            r_clock      <= '0;
            r_tlb_valid  <= '0;
            r_tlb_ptr    <= '0;
            r_occ        <= '0;
            r_victim_ptr <= '0;
            r_scan_issue <= 1'b0;
            r_cmp_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (i_cmd.accept) begin
                r_clock <= r_clock + 1'b1;
            end
            if (i_cmd.look && !tlb_hit && !frm_hit && all_full && !r_mode) begin
                r_victim_ptr <= (r_victim_ptr == FRAME_LAST) ? '0 : r_victim_ptr + 1'b1;
            end
            if (i_cmd.look) begin
                r_scan_issue <= o_status.need_scan;
                r_cmp_valid  <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cmp_valid <= r_scan_issue;
                if (r_scan_issue && r_scan_addr == FRAME_LAST) begin
                    r_scan_issue <= 1'b0;
                end
            end else begin
                r_cmp_valid <= 1'b0;
            end
            if (i_cmd.commit) begin
                if (!r_hit) begin
                    // The entry being filled is set below, so it is skipped here.
                    for (int i = 0; i < TLB_ENTRIES; i++) begin
                        if (r_fault && r_tlb_frame[i] == r_frame && TW'(i) != r_tlb_ptr) begin
                            r_tlb_valid[i] <= 1'b0;
                        end
                    end
                    r_tlb_valid[r_tlb_ptr] <= 1'b1;
                    r_tlb_ptr <= (r_tlb_ptr == TLB_LAST) ? '0 : r_tlb_ptr + 1'b1;
                end
                if (r_fault) begin
                    r_occ[r_frame] <= 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_offset <= i_virtual_address[OFFSET_WIDTH-1:0];
            r_page   <= i_virtual_address[VW-1:OFFSET_WIDTH];
        end
        if (i_cmd.look) begin
            r_hit       <= tlb_hit;
            r_fault     <= !tlb_hit && !frm_hit;
            r_scan_addr <= '0;
            r_best      <= '1;
            if (tlb_hit) begin
                r_frame <= r_tlb_frame[tlb_idx];
            end else if (frm_hit) begin
                r_frame <= frm_idx;
            end else if (!all_full) begin
                r_frame <= empty_idx;
            end else begin
                r_frame <= r_victim_ptr;
            end
        end
        if (i_cmd.scan) begin
            if (r_scan_issue) begin
                r_scan_addr <= r_scan_addr + 1'b1;
            end
            r_cmp_idx <= r_scan_addr;
            // Ties go to the later frame, so the highest index among equal minima wins.
            if (r_cmp_valid && r_stamp_rd <= r_best) begin
                r_best  <= r_stamp_rd;
                r_frame <= r_cmp_idx;
            end
        end
        if (i_cmd.commit) begin
            if (!r_hit) begin
                r_tlb_tag[r_tlb_ptr]   <= r_page;
                r_tlb_frame[r_tlb_ptr] <= r_frame;
            end
            if (r_fault) begin
                r_owner[r_frame] <= r_page;
            end
            r_out_pa    <= {r_frame, r_offset};
            r_out_hit   <= r_hit;
            r_out_fault <= r_fault;
        end
    end

    // Last-use stamp memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_stamp_mem[r_frame] <= r_clock;
        end
        r_stamp_rd <= r_stamp_mem[r_scan_addr];
    end

    assign o_valid      = r_out_valid;
    assign o_phys_addr  = r_out_pa;
    assign o_tlb_hit    = r_out_hit;
    assign o_page_fault = r_out_fault;

endmodule

@@ design/tlb_page_translator.sv @@
// Top level of the TLB page translator: controller and datapath.
// Each accepted address passes through lookup and then commit, with a scan of the stamp memory
// between them when a fault with all frames full and LRU replacement selected needs a victim.
// Transactions are taken one at a time (accept, lookup, commit); the LRU scan reads one
// stamp per cycle, and a result left waiting holds the commit.
// Reset (synchronous, active low) empties the TLB and frame table and clears the TLB and victim pointers.
module tlb_page_translator
    import tlb_pt_pkg::*;
#(
    parameter int TLB_ENTRIES       = TLB_ENTRIES_DEFAULT,
    parameter int FRAME_COUNT       = FRAME_COUNT_DEFAULT,
    parameter int OFFSET_WIDTH      = OFFSET_WIDTH_DEFAULT,
    parameter int PAGE_NUMBER_WIDTH = PAGE_NUMBER_WIDTH_DEFAULT
)
(
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_cfg_wr_en,
    input  logic                                          i_cfg_wr_data,
    input  logic                                          i_valid,
    output logic                                          o_ready,
    input  logic [OFFSET_WIDTH+PAGE_NUMBER_WIDTH-1:0]     i_virtual_address,
    output logic                                          o_valid,
    input  logic                                          i_ready,
    output logic [$clog2(FRAME_COUNT)+OFFSET_WIDTH-1:0]   o_phys_addr,
    output logic                                          o_tlb_hit,
    output logic                                          o_page_fault
);

    // The controller sequences one transaction at a time through lookup, an optional
    // LRU scan and a commit step; the datapath holds every table and the output register,
    // so a finished result waits there while the next transaction is accepted.
    t_cmd    cmd;
    t_status status;

    tlb_pt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    tlb_pt_dpath #(
        .TLB_ENTRIES       (TLB_ENTRIES),
        .FRAME_COUNT       (FRAME_COUNT),
        .OFFSET_WIDTH      (OFFSET_WIDTH),
        .PAGE_NUMBER_WIDTH (PAGE_NUMBER_WIDTH)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_virtual_address (i_virtual_address),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_ready           (i_ready),
        .o_valid           (o_valid),
        .o_phys_addr       (o_phys_addr),
        .o_tlb_hit         (o_tlb_hit),
        .o_page_fault      (o_page_fault)
    );

endmodule

@@ sim/tlb_page_translator_test.sv @@
// Self-checking testbench for the TLB page translator with a translation scoreboard.

// Predicts translations from a private copy of the TLB and frame table and holds expected results.
class translation_scoreboard;
    localparam int TLB_N = 16;
    localparam int FRAME_N = 64;

    typedef struct packed {
        logic [13:0] phys;
        logic        hit;
        logic        fault;
    } t_translation;

    bit          lru_mode;
    logic [7:0]  tag_mem [TLB_N];
    logic [5:0]  tlb_frame [TLB_N];
    bit          tag_valid [TLB_N];
    logic [3:0]  insert_ptr;
    logic [7:0]  owner [FRAME_N];
    bit          occupied [FRAME_N];
    logic [31:0] last_use [FRAME_N];
    logic [31:0] access_count;
    logic [5:0]  victim_ptr;
    t_translation pending[$];
    int          errors;
    int          checked;
    int          hits;
    int          faults;
    int          replacements;

    function void clear();
        lru_mode = 0;
        insert_ptr = 0;
        access_count = 0;
        victim_ptr = 0;
        for (int i = 0; i < TLB_N; i++) begin
            tag_valid[i] = 0;
            tag_mem[i] = 0;
            tlb_frame[i] = 0;
        end
        for (int i = 0; i < FRAME_N; i++) begin
            occupied[i] = 0;
            owner[i] = 0;
            last_use[i] = 0;
        end
        pending.delete();
    endfunction

    // Notes an accepted address and queues the translation it must produce.
    function void note_address(logic [15:0] va);
        logic [7:0]   page;
        int           slot;
        int           frame;
        logic [31:0]  oldest;
        t_translation exp_t;
        page = va[15:8];
        slot = -1;
        frame = -1;
        exp_t = '0;
        access_count = access_count + 32'd1;
        for (int i = TLB_N - 1; i >= 0; i--)
            if (tag_valid[i] && tag_mem[i] == page) slot = i;
        if (slot >= 0) begin
            exp_t.hit = 1;
            frame = tlb_frame[slot];
        end else begin
            for (int i = FRAME_N - 1; i >= 0; i--)
                if (occupied[i] && owner[i] == page) frame = i;
            if (frame < 0) begin
                exp_t.fault = 1;
                for (int i = FRAME_N - 1; i >= 0; i--)
                    if (!occupied[i]) frame = i;
                if (frame < 0) begin
                    replacements++;
                    if (!lru_mode) begin
                        frame = victim_ptr;
                        victim_ptr = victim_ptr + 6'd1;
                    end else begin
                        // Ties go to the highest frame, hence the <= comparison.
                        oldest = 32'hFFFF_FFFF;
                        for (int i = 0; i < FRAME_N; i++)
                            if (last_use[i] <= oldest) begin
                                oldest = last_use[i];
                                frame = i;
                            end
                    end
                end
                for (int i = 0; i < TLB_N; i++)
                    if (tag_valid[i] && tlb_frame[i] == frame) tag_valid[i] = 0;
                owner[frame] = page;
                occupied[frame] = 1;
            end
            tag_mem[insert_ptr] = page;
            tlb_frame[insert_ptr] = 6'(frame);
            tag_valid[insert_ptr] = 1;
            insert_ptr = insert_ptr + 4'd1;
        end
        last_use[frame] = access_count;
        exp_t.phys = {frame[5:0], va[7:0]};
        pending.push_back(exp_t);
    endfunction

    // Compares one delivered translation with the oldest one expected.
    function void check_translation(logic [13:0] phys, logic hit, logic fault);
        t_translation exp_t;
        if (pending.size() == 0) begin
            $error("unexpected translation: phys_addr %h", phys);
            errors++;
            return;
        end
        exp_t = pending.pop_front();
        checked++;
        if (exp_t.hit) hits++;
        if (exp_t.fault) faults++;
        if (phys !== exp_t.phys) begin
            $error("phys_addr: expected %h, actual %h", exp_t.phys, phys);
            errors++;
        end
        if (hit !== exp_t.hit) begin
            $error("tlb_hit: expected %b, actual %b", exp_t.hit, hit);
            errors++;
        end
        if (fault !== exp_t.fault) begin
            $error("page_fault: expected %b, actual %b", exp_t.fault, fault);
            errors++;
        end
    endfunction
endclass

module tlb_page_translator_test;
    import tlb_pt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    // Longest LRU scan plus handshake overhead, used for the settling pause at the end of each drain.
    localparam int DRAIN_CYCLES = FRAME_COUNT_DEFAULT + 10;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_wr_en = 0;
    logic        i_cfg_wr_data = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [15:0] i_virtual_address = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [13:0] o_phys_addr;
    logic        o_tlb_hit;
    logic        o_page_fault;

    translation_scoreboard board = new();
    int  cycle_count = 0;
    bit  rx_enable = 0;
    int  sent = 0;

    always #5 i_clk = ~i_clk;

    tlb_page_translator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_virtual_address (i_virtual_address),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_phys_addr       (o_phys_addr),
        .o_tlb_hit         (o_tlb_hit),
        .o_page_fault      (o_page_fault)
    );

    // Gap lengths are mostly zero or short, with the occasional long stretch.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // The receiver samples results at the edge and toggles its ready at random.
    // Phases with no back-pressure alternate with phases of random stalls.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
        if (o_valid && i_ready) board.check_translation(o_phys_addr, o_tlb_hit,
                                                        o_page_fault);
    end

    initial begin : receiver
        int stall;
        forever begin
            @(posedge i_clk);
            if (!rx_enable) begin
                i_ready <= 0;
            end else if (sent % 200 < 60) begin
                // A stretch where results are always taken at once.
                i_ready <= 1;
            end else begin
                stall = gap_length();
                if (stall == 0) begin
                    i_ready <= 1;
                end else begin
                    i_ready <= 0;
                    repeat (stall - 1) @(posedge i_clk);
                end
            end
        end
    end

    // Offers one address and waits until the block takes the transaction. Valid stays
    // high after acceptance so that a following address with no gap goes out at once;
    // a gap or a drain drops it.
    task automatic send_address(logic [15:0] va, bit with_gap);
        int gap;
        gap = with_gap ? gap_length() : 0;
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_virtual_address <= va;
        do @(posedge i_clk); while (!(o_ready && i_valid));
        board.note_address(va);
        sent++;
    endtask

    // Waits for every expected translation, then lets the block settle.
    task automatic drain();
        i_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(bit lru);
        drain();
        i_cfg_wr_en <= 1;
        i_cfg_wr_data <= lru;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        board.lru_mode = lru;
    endtask

    // Draws a page from a small working set most of the time so hits and
    // replacements both happen often, and from the whole space otherwise.
    function automatic logic [15:0] random_address(int span);
        logic [7:0] page;
        if ($urandom_range(0, 3) != 0) page = 8'($urandom_range(0, span - 1));
        else page = 8'($urandom_range(0, 255));
        return {page, 8'($urandom())};
    endfunction

    initial begin
        board.clear();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        rx_enable = 1;

        // Directed part: extreme addresses, a repeated page for a TLB hit, and
        // the same page again after the TLB has rolled over for a frame-table hit.
        send_address(16'h0000, 0);
        send_address(16'hFFFF, 0);
        send_address(16'h00FF, 0);
        send_address(16'hFF00, 0);
        send_address(16'hA55A, 0);
        send_address(16'h5AA5, 0);
        for (int i = 1; i <= 17; i++) send_address({8'(i), 8'(i * 13)}, 0);
        send_address(16'h0042, 0);

        // FIFO phase: fill every frame and then force replacements, with
        // stale TLB entries to be invalidated along the way.
        for (int i = 0; i < 200; i++) send_address(random_address(96), 1);

        // The sender holds off until every translation has come back.
        drain();
        for (int i = 0; i < 150; i++) send_address(random_address(80), 1);

        set_mode(1);
        for (int i = 0; i < 250; i++) send_address(random_address(90), 1);

        set_mode(0);
        for (int i = 0; i < 100; i++) send_address(random_address(256), 1);

        set_mode(1);
        for (int i = 0; i < 125; i++) send_address(random_address(70), 1);

        drain();
        $display("Translated %0d addresses: %0d TLB hits, %0d faults, %0d replacements,",
                 board.checked, board.hits, board.faults, board.replacements);
        $display("in FIFO and LRU modes with random stalls on both channels.");
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
